// ===== rtl/cpsat_pkg.sv =====
`default_nettype none
package cpsat_pkg;

  // field and datapath widths
  localparam int VW   = 24;          // vertex coordinate, Q16.8
  localparam int AXW  = 25;          // edge normal component
  localparam int MAW  = 27;          // multiplier operand a
  localparam int MBW  = 25;          // multiplier operand b
  localparam int MPW  = 52;          // multiplier product
  localparam int AW   = 78;          // accumulator
  localparam int PW   = 52;          // projection
  localparam int DVW  = 78;          // divider dividend / quotient
  localparam int DSW  = 25;          // divider divisor
  localparam int SQW  = 50;          // square root radicand
  localparam int SRW  = 25;          // square root result
  localparam int DEPW = 51;          // normalized depth
  localparam int MW   = 52;          // depth minus one
  localparam int MLW  = 26;          // low slice of depth minus one

  localparam logic [MW-1:0]  ONE_Q8  = MW'(256);
  localparam logic [VW-1:0]  SAT_MAX = 24'h7FFFFF;
  localparam logic [VW-1:0]  SAT_MIN = 24'h800000;
  localparam logic [DVW-1:0] POS_LIM = DVW'(24'h7FFFFF);
  localparam logic [DVW-1:0] NEG_LIM = DVW'(25'h0800000);

  typedef struct packed {
    logic                 which_shape;
    logic signed [VW-1:0] vertex_x;
    logic signed [VW-1:0] vertex_y;
    logic                 shape_is_circle;
    logic                 last_of_shape;
  } in_word_t;

  typedef struct packed {
    logic                 collision;
    logic signed [VW-1:0] push_x;
    logic signed [VW-1:0] push_y;
  } out_word_t;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] num;
    logic [DSW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic [DVW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic           start;
    logic [SQW-1:0] val;
  } sq_req_t;

  typedef struct packed {
    logic           busy;
    logic [SRW-1:0] root;
  } sq_rsp_t;

  typedef enum logic [1:0] {J_RA, J_RB, J_DC, J_LEN} job_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CS_RD, ST_CS_ACC, ST_CS_DX, ST_CS_WX, ST_CS_DY, ST_CS_WY,
    ST_RA_RD, ST_RA_SET, ST_RB_RD, ST_RB_SET, ST_DC_SET, ST_DC_CHK,
    ST_SQ_X, ST_SQ_Y, ST_SQ_ADD, ST_SQ_ROOT, ST_SQ_WAIT,
    ST_ED_RDI, ST_ED_RDJ, ST_ED_AX,
    ST_PR_RD, ST_PR_MX, ST_PR_MY, ST_PR_ADD, ST_PR_CHK,
    ST_LEN_CHK, ST_DEP_WAIT,
    ST_PU_MX, ST_PU_MY, ST_PU_DOT, ST_PU_M0, ST_PU_M1, ST_PU_M2,
    ST_PU_DIV, ST_PU_WAIT, ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/cpsat_div.sv =====
`default_nettype none
module cpsat_div
  import cpsat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNW = $clog2(DVW);

  logic           busy_r;
  logic [CNW-1:0] cnt_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] den_r;
  logic [DSW:0]   rem_sh;
  logic [DSW:0]   diff;
  logic           ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quo_r[DVW-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      cnt_r <= CNW'(DVW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
      quo_r <= {quo_r[DVW-2:0], ge};
      cnt_r <= cnt_r - CNW'(1);
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/cpsat_sqrt.sv =====
`default_nettype none
module cpsat_sqrt
  import cpsat_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  sq_req_t req,
  output sq_rsp_t rsp
);

  localparam int CNW = $clog2(SRW);

  logic           busy_r;
  logic [CNW-1:0] cnt_r;
  logic [SQW-1:0] val_r;
  logic [SRW:0]   rem_r;
  logic [SRW-1:0] root_r;
  logic [SRW+2:0] rem_sh;
  logic [SRW+2:0] trial;
  logic [SRW+2:0] sub;
  logic           ge;

  // one root bit per cycle from two radicand bits
  assign rem_sh = {rem_r, val_r[SQW-1:SQW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sub    = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val_r  <= req.val;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNW'(SRW - 1);
    end else if (busy_r) begin
      val_r  <= {val_r[SQW-3:0], 2'b00};
      rem_r  <= ge ? sub[SRW:0] : rem_sh[SRW:0];
      root_r <= {root_r[SRW-2:0], ge};
      cnt_r  <= cnt_r - CNW'(1);
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.root = root_r;

endmodule
`default_nettype wire

// ===== rtl/convex_polygon_sat_collision_top.sv =====
`default_nettype none
// Separating-axis collision test for two convex polygons in signed Q16.8. Vertices of
// polygon A and then B are taken one word a cycle while idle; the last word of B starts
// the test and the block stalls its input until the result word is in the output
// register. The test runs on one shared 27x25 multiplier, a serial divider and a serial
// square root under a sequencer: it finds both centres, compares the centre distance
// with the two radii when both shapes are circles, projects both polygons onto the normal
// of each of the na+nb edges and then works out the push vector; an early separating
// axis ends it sooner.
module convex_polygon_sat_collision_top
  import cpsat_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int SUMW = VW + CW;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_a_r, count_b_r;
  logic [1:0]    circ_r;
  logic          out_valid_r;
  out_word_t     out_data_r;
  logic          in_acc;

  // vertex stores
  logic [2*VW-1:0] mem_a [MAX_VERTICES];
  logic [2*VW-1:0] mem_b [MAX_VERTICES];
  logic [2*VW-1:0] rd_a_r, rd_b_r;
  logic [IW-1:0]   rd_idx;
  logic            rd_sel;
  logic signed [VW-1:0] rd_x, rd_y;

  // sequencer counters
  logic          s_r, pass_r, c_r;
  logic [CW-1:0] k_r, i_r, j_v, n_s, n_p;
  logic          k_last_s, k_last_p, i_last;
  job_t          job_r;

  // datapath
  logic signed [SUMW-1:0] sx_r, sy_r;
  logic [SUMW-1:0]        abs_sx, abs_sy;
  logic signed [VW-1:0]   cax_r, cay_r, cbx_r, cby_r;
  logic signed [AXW-1:0]  opx_r, opy_r, dcx, dcy;
  logic [SRW-1:0]         ra_r, rb_r, dc_r, len_r, best_len_r;
  logic signed [VW-1:0]   vix_r, viy_r;
  logic signed [AXW-1:0]  ax_r, ay_r, bax_r, bay_r, bc;
  logic signed [PW-1:0]   mina_r, maxa_r, minb_r, maxb_r, proj, o1, o2;
  logic [PW-1:0]          o_r;
  logic [DEPW-1:0]        best_depth_r, depth;
  logic                   have_r, hit_r, sgn_r, sep;
  logic signed [VW-1:0]   px_r, py_r, cq, push_val;
  logic [VW-1:0]          q24;
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [MPW-1:0]  prod_r;
  logic signed [AW-1:0]   acc_r, prod_ext, dot_v;
  logic [AW-1:0]          abs_acc;
  logic [MW-1:0]          m_v;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sq_req_t  sq_req;
  sq_rsp_t  sq_rsp;

  cpsat_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  cpsat_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // loop bookkeeping
  assign n_s      = s_r ? count_b_r : count_a_r;
  assign n_p      = pass_r ? count_b_r : count_a_r;
  assign k_last_s = (k_r + CW'(1)) == n_s;
  assign k_last_p = (k_r + CW'(1)) == n_p;
  assign i_last   = (i_r + CW'(1)) == n_s;
  assign j_v      = i_last ? '0 : i_r + CW'(1);

  // arithmetic helpers
  assign rd_x     = rd_sel ? rd_b_r[2*VW-1:VW] : rd_a_r[2*VW-1:VW];
  assign rd_y     = rd_sel ? rd_b_r[VW-1:0] : rd_a_r[VW-1:0];
  assign abs_sx   = sx_r[SUMW-1] ? SUMW'(-sx_r) : SUMW'(sx_r);
  assign abs_sy   = sy_r[SUMW-1] ? SUMW'(-sy_r) : SUMW'(sy_r);
  assign dcx      = AXW'(cbx_r) - AXW'(cax_r);
  assign dcy      = AXW'(cby_r) - AXW'(cay_r);
  assign prod_ext = AW'(prod_r);
  assign proj     = $signed(acc_r[PW-1:0]) + prod_r;
  assign dot_v    = acc_r + prod_ext;
  assign abs_acc  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign sep      = (mina_r >= maxb_r) || (minb_r >= maxa_r);
  assign o1       = maxb_r - mina_r;
  assign o2       = maxa_r - minb_r;
  assign depth    = div_rsp.quo[DEPW-1:0];
  assign m_v      = {{(MW-DEPW){1'b0}}, best_depth_r} - ONE_Q8;
  assign bc       = c_r ? bay_r : bax_r;
  assign q24      = div_rsp.quo[VW-1:0];
  assign cq       = sgn_r ? $signed(-q24) : $signed(q24);

  // signed quotient with saturation
  always_comb begin
    if (!sgn_r) begin
      push_val = (div_rsp.quo > POS_LIM) ? $signed(SAT_MAX) : $signed(q24);
    end else begin
      push_val = (div_rsp.quo > NEG_LIM) ? $signed(SAT_MIN) : $signed(-q24);
    end
  end

  // vertex stores, registered reads
  always_ff @(posedge clk) begin
    if (in_acc && !in_data.which_shape && count_a_r < CW'(MAX_VERTICES)) begin
      mem_a[count_a_r[IW-1:0]] <= {in_data.vertex_x, in_data.vertex_y};
    end
    if (in_acc && in_data.which_shape && count_b_r < CW'(MAX_VERTICES)) begin
      mem_b[count_b_r[IW-1:0]] <= {in_data.vertex_x, in_data.vertex_y};
    end
    rd_a_r <= mem_a[rd_idx];
    rd_b_r <= mem_b[rd_idx];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit controls
  always_comb begin
    state_nxt     = state_r;
    rd_idx        = '0;
    rd_sel        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    sq_req.start  = 1'b0;
    sq_req.val    = acc_r[SQW-1:0];

    if (state_r inside {ST_CS_RD, ST_CS_ACC}) begin
      rd_idx = k_r[IW-1:0];
      rd_sel = s_r;
    end else if (state_r inside {ST_PR_RD, ST_PR_MX, ST_PR_MY}) begin
      rd_idx = k_r[IW-1:0];
      rd_sel = pass_r;
    end else if (state_r inside {ST_ED_RDI}) begin
      rd_idx = i_r[IW-1:0];
      rd_sel = s_r;
    end else if (state_r inside {ST_ED_RDJ, ST_ED_AX}) begin
      rd_idx = j_v[IW-1:0];
      rd_sel = s_r;
    end else if (state_r inside {ST_RB_RD, ST_RB_SET}) begin
      rd_sel = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.which_shape && in_data.last_of_shape) begin
          state_nxt = (count_a_r == '0) ? ST_FIN : ST_CS_RD;
        end
      end
      ST_CS_RD:  state_nxt = ST_CS_ACC;
      ST_CS_ACC: state_nxt = k_last_s ? ST_CS_DX : ST_CS_RD;
      ST_CS_DX: begin
        div_req.start = 1'b1;
        div_req.num   = {{(DVW-SUMW){1'b0}}, abs_sx};
        div_req.den   = {{(DSW-CW){1'b0}}, n_s};
        state_nxt     = ST_CS_WX;
      end
      ST_CS_WX: if (!div_rsp.busy) state_nxt = ST_CS_DY;
      ST_CS_DY: begin
        div_req.start = 1'b1;
        div_req.num   = {{(DVW-SUMW){1'b0}}, abs_sy};
        div_req.den   = {{(DSW-CW){1'b0}}, n_s};
        state_nxt     = ST_CS_WY;
      end
      ST_CS_WY: begin
        if (!div_rsp.busy) begin
          if (!s_r) state_nxt = ST_CS_RD;
          else if (circ_r == 2'b11) state_nxt = ST_RA_RD;
          else state_nxt = ST_ED_RDI;
        end
      end
      ST_RA_RD:  state_nxt = ST_RA_SET;
      ST_RA_SET: state_nxt = ST_SQ_X;
      ST_RB_RD:  state_nxt = ST_RB_SET;
      ST_RB_SET: state_nxt = ST_SQ_X;
      ST_DC_SET: state_nxt = ST_SQ_X;
      ST_DC_CHK: begin
        state_nxt = ({1'b0, dc_r} < ({1'b0, ra_r} + {1'b0, rb_r})) ? ST_ED_RDI : ST_FIN;
      end
      ST_SQ_X: begin
        mul_a     = MAW'(opx_r);
        mul_b     = opx_r;
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        mul_a     = MAW'(opy_r);
        mul_b     = opy_r;
        state_nxt = ST_SQ_ADD;
      end
      ST_SQ_ADD: state_nxt = ST_SQ_ROOT;
      ST_SQ_ROOT: begin
        sq_req.start = 1'b1;
        state_nxt    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (!sq_rsp.busy) begin
          case (job_r)
            J_RA:    state_nxt = ST_RB_RD;
            J_RB:    state_nxt = ST_DC_SET;
            J_DC:    state_nxt = ST_DC_CHK;
            J_LEN:   state_nxt = ST_LEN_CHK;
            default: state_nxt = ST_LEN_CHK;
          endcase
        end
      end
      ST_ED_RDI: state_nxt = ST_ED_RDJ;
      ST_ED_RDJ: state_nxt = ST_ED_AX;
      ST_ED_AX:  state_nxt = ST_PR_RD;
      ST_PR_RD:  state_nxt = ST_PR_MX;
      ST_PR_MX: begin
        mul_a     = MAW'(rd_x);
        mul_b     = ax_r;
        state_nxt = ST_PR_MY;
      end
      ST_PR_MY: begin
        mul_a     = MAW'(rd_y);
        mul_b     = ay_r;
        state_nxt = ST_PR_ADD;
      end
      ST_PR_ADD: begin
        if (k_last_p && pass_r) state_nxt = ST_PR_CHK;
        else state_nxt = ST_PR_RD;
      end
      ST_PR_CHK: state_nxt = sep ? ST_FIN : ST_SQ_X;
      ST_LEN_CHK: begin
        if (len_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {{(DVW-PW){1'b0}}, o_r};
          div_req.den   = len_r;
          state_nxt     = ST_DEP_WAIT;
        end
      end
      ST_DEP_WAIT: begin
        if (!div_rsp.busy) begin
          state_nxt = (i_last && s_r) ? ST_PU_MX : ST_ED_RDI;
        end
      end
      ST_PU_MX: begin
        mul_a     = MAW'(dcx);
        mul_b     = bax_r;
        state_nxt = ST_PU_MY;
      end
      ST_PU_MY: begin
        mul_a     = MAW'(dcy);
        mul_b     = bay_r;
        state_nxt = ST_PU_DOT;
      end
      ST_PU_DOT: state_nxt = ST_PU_M0;
      ST_PU_M0: begin
        mul_a     = MAW'({1'b0, m_v[MLW-1:0]});
        mul_b     = bc;
        state_nxt = ST_PU_M1;
      end
      ST_PU_M1: begin
        mul_a     = MAW'($signed(m_v[MW-1:MLW]));
        mul_b     = bc;
        state_nxt = ST_PU_M2;
      end
      ST_PU_M2: state_nxt = ST_PU_DIV;
      ST_PU_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = abs_acc;
        div_req.den   = best_len_r;
        state_nxt     = ST_PU_WAIT;
      end
      ST_PU_WAIT: begin
        if (!div_rsp.busy) state_nxt = c_r ? ST_FIN : ST_PU_M0;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counts, circle flags and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      circ_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!in_data.which_shape) begin
          if (count_a_r < CW'(MAX_VERTICES)) count_a_r <= count_a_r + CW'(1);
          circ_r[0] <= in_data.shape_is_circle;
        end else begin
          if (count_b_r < CW'(MAX_VERTICES)) count_b_r <= count_b_r + CW'(1);
          circ_r[1] <= in_data.shape_is_circle;
        end
      end
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        count_a_r   <= '0;
        count_b_r   <= '0;
        circ_r      <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        s_r    <= 1'b0;
        k_r    <= '0;
        sx_r   <= '0;
        sy_r   <= '0;
        hit_r  <= 1'b0;
        have_r <= 1'b0;
      end
      ST_CS_ACC: begin
        sx_r <= sx_r + SUMW'(rd_x);
        sy_r <= sy_r + SUMW'(rd_y);
        k_r  <= k_r + CW'(1);
      end
      ST_CS_DX: sgn_r <= sx_r[SUMW-1];
      ST_CS_WX: begin
        if (!div_rsp.busy) begin
          if (s_r) cbx_r <= cq;
          else cax_r <= cq;
        end
      end
      ST_CS_DY: sgn_r <= sy_r[SUMW-1];
      ST_CS_WY: begin
        if (!div_rsp.busy) begin
          if (s_r) cby_r <= cq;
          else cay_r <= cq;
          s_r  <= ~s_r;
          k_r  <= '0;
          i_r  <= '0;
          sx_r <= '0;
          sy_r <= '0;
        end
      end
      ST_RA_SET: begin
        opx_r <= AXW'(rd_x) - AXW'(cax_r);
        opy_r <= AXW'(rd_y) - AXW'(cay_r);
        job_r <= J_RA;
      end
      ST_RB_SET: begin
        opx_r <= AXW'(rd_x) - AXW'(cbx_r);
        opy_r <= AXW'(rd_y) - AXW'(cby_r);
        job_r <= J_RB;
      end
      ST_DC_SET: begin
        opx_r <= dcx;
        opy_r <= dcy;
        job_r <= J_DC;
      end
      ST_DC_CHK: begin
        s_r <= 1'b0;
        i_r <= '0;
      end
      ST_SQ_Y:   acc_r <= prod_ext;
      ST_SQ_ADD: acc_r <= acc_r + prod_ext;
      ST_SQ_WAIT: begin
        if (!sq_rsp.busy) begin
          case (job_r)
            J_RA:    ra_r  <= sq_rsp.root;
            J_RB:    rb_r  <= sq_rsp.root;
            J_DC:    dc_r  <= sq_rsp.root;
            J_LEN:   len_r <= sq_rsp.root;
            default: len_r <= sq_rsp.root;
          endcase
        end
      end
      ST_ED_RDJ: begin
        vix_r <= rd_x;
        viy_r <= rd_y;
      end
      ST_ED_AX: begin
        ax_r   <= AXW'(viy_r) - AXW'(rd_y);
        ay_r   <= AXW'(rd_x) - AXW'(vix_r);
        pass_r <= 1'b0;
        k_r    <= '0;
      end
      ST_PR_MY: acc_r <= prod_ext;
      ST_PR_ADD: begin
        if (!pass_r) begin
          if (k_r == '0 || proj < mina_r) mina_r <= proj;
          if (k_r == '0 || proj > maxa_r) maxa_r <= proj;
        end else begin
          if (k_r == '0 || proj < minb_r) minb_r <= proj;
          if (k_r == '0 || proj > maxb_r) maxb_r <= proj;
        end
        if (k_last_p) begin
          pass_r <= 1'b1;
          k_r    <= '0;
        end else begin
          k_r <= k_r + CW'(1);
        end
      end
      ST_PR_CHK: begin
        o_r   <= (o1 < o2) ? o1 : o2;
        opx_r <= ax_r;
        opy_r <= ay_r;
        job_r <= J_LEN;
      end
      ST_DEP_WAIT: begin
        if (!div_rsp.busy) begin
          // ties keep the earlier axis
          if (!have_r || depth < best_depth_r) begin
            have_r       <= 1'b1;
            best_depth_r <= depth;
            best_len_r   <= len_r;
            bax_r        <= ax_r;
            bay_r        <= ay_r;
          end
          if (i_last) begin
            s_r <= 1'b1;
            i_r <= '0;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
      end
      ST_PU_MY: acc_r <= prod_ext;
      ST_PU_DOT: begin
        // point the push away from the centre of B
        if (!dot_v[AW-1] && (dot_v != '0)) begin
          bax_r <= -bax_r;
          bay_r <= -bay_r;
        end
        c_r <= 1'b0;
      end
      ST_PU_M1: acc_r <= prod_ext;
      ST_PU_M2: acc_r <= acc_r + (prod_ext <<< MLW);
      ST_PU_DIV: sgn_r <= acc_r[AW-1];
      ST_PU_WAIT: begin
        if (!div_rsp.busy) begin
          if (c_r) begin
            py_r  <= push_val;
            hit_r <= 1'b1;
          end else begin
            px_r <= push_val;
          end
          c_r <= 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.collision <= hit_r;
          out_data_r.push_x    <= hit_r ? px_r : '0;
          out_data_r.push_y    <= hit_r ? py_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word raised outside the finish step");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(MAX_VERTICES)) && (count_b_r <= CW'(MAX_VERTICES)))
    else $error("vertex count beyond store depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.collision |->
      (out_data_r.push_x == '0) && (out_data_r.push_y == '0))
    else $error("push vector not zero without collision");

endmodule
`default_nettype wire
